// ===== hdl/size_class_pool_allocator_macros.svh =====
`ifndef SIZE_CLASS_POOL_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define SCPA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("size_class_pool_allocator: check failed");

// next-cycle implication
`define SCPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("size_class_pool_allocator: check failed");

`endif

// ===== hdl/scpa_pkg.sv =====
package scpa_pkg;

   localparam int NUM_CLASSES   = 4;
   localparam int CLASS_W       = $clog2(NUM_CLASSES);
   localparam int CLASS0_CHUNKS = 64;
   localparam int CLASS1_CHUNKS = 128;
   localparam int CLASS2_CHUNKS = 32;
   localparam int CLASS3_CHUNKS = 16;
   localparam int TOTAL_CHUNKS  = CLASS0_CHUNKS + CLASS1_CHUNKS + CLASS2_CHUNKS
                                  + CLASS3_CHUNKS;
   localparam int ADDR_W        = $clog2(TOTAL_CHUNKS);
   localparam int HANDLE_W      = 8;
   localparam int LINK_W        = 9;
   localparam int SIZE_W        = 16;
   localparam int REG_ADDR_W    = CLASS_W + 2;
   localparam int DATA_W        = 32;

   typedef logic [LINK_W-1:0]  link_type;
   typedef logic [CLASS_W-1:0] class_type;
   typedef logic [SIZE_W-1:0]  size_type;
   typedef logic [ADDR_W-1:0]  addr_type;

   localparam link_type END_MARK = '1;

   typedef enum logic [1:0] {
      ST_ALLOCATED = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_TOO_LARGE = 2'd2,
      ST_FREED     = 2'd3
   } status_type;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      link_type wr_data;
      logic     rd_en;
      addr_type rd_addr;
   } link_req_type;

   function automatic int class_count(int c);
      case (c)
         0:       return CLASS0_CHUNKS;
         1:       return CLASS1_CHUNKS;
         2:       return CLASS2_CHUNKS;
         default: return CLASS3_CHUNKS;
      endcase
   endfunction

   function automatic int class_base(int c);
      int base;
      base = 0;
      for (int k = 0; k < c; k++) base += class_count(k);
      return base;
   endfunction

   function automatic link_type class_last(int c);
      return LINK_W'(class_base(c) + class_count(c) - 1);
   endfunction

   function automatic size_type default_limit(int c);
      case (c)
         0:       return SIZE_W'(16);
         1:       return SIZE_W'(64);
         2:       return SIZE_W'(128);
         default: return SIZE_W'(2048);
      endcase
   endfunction

   // link value of an entry never written since reset
   function automatic link_type reset_link(addr_type a);
      logic first;
      first = 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (a == ADDR_W'(class_base(c))) first = 1'b1;
      end
      return first ? END_MARK : LINK_W'(a) - LINK_W'(1);
   endfunction

endpackage

// ===== hdl/scpa_link_ram.sv =====
module scpa_link_ram (
   input  logic                  clock,
   input  logic                  reset,
   input  scpa_pkg::link_req_type req,
   output scpa_pkg::link_type     rd_link
);
   import scpa_pkg::*;

   link_type                link_mem [TOTAL_CHUNKS];
   logic [TOTAL_CHUNKS-1:0] valid_ff;
   logic [TOTAL_CHUNKS-1:0] valid_in;
   link_type                rd_data_ff;
   logic                    rd_hit_ff;
   addr_type                rd_addr_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req.wr_en) valid_in[req.wr_addr] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) link_mem[req.wr_addr] <= req.wr_data;
      if (req.rd_en) begin
         rd_data_ff <= link_mem[req.rd_addr];
         rd_hit_ff  <= valid_ff[req.rd_addr];
         rd_addr_ff <= req.rd_addr;
      end
   end

   assign rd_link = rd_hit_ff ? rd_data_ff : reset_link(rd_addr_ff);

endmodule

// ===== hdl/size_class_pool_allocator.sv =====
// Latency: the result strobe rsp_valid comes in the cycle after start is taken.
// Throughput: one request per cycle; busy is never raised and the receiver
// cannot stall, so results are never held back.
// A pop's next link comes from the link RAM in the next cycle and is forwarded.
// Reset (synchronous): list heads, size limits and link valid bits return to
// their defaults with no clearing pass.
module size_class_pool_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_command,
   input  scpa_pkg::size_type                req_request_size,
   input  logic                              req_handle_present,
   input  logic [scpa_pkg::HANDLE_W-1:0]     req_chunk_handle,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [scpa_pkg::HANDLE_W-1:0]     rsp_granted_handle,
   output scpa_pkg::class_type               rsp_size_class,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [scpa_pkg::REG_ADDR_W-1:0]   paddr,
   input  logic [scpa_pkg::DATA_W-1:0]       pwdata,
   output logic [scpa_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);
   import scpa_pkg::*;

   size_type     limit_ff [NUM_CLASSES];
   size_type     limit_in [NUM_CLASSES];
   link_type     head_ff  [NUM_CLASSES];
   link_type     head_in  [NUM_CLASSES];
   link_type     head_eff [NUM_CLASSES];
   logic         pend_ff, pend_in;
   class_type    pend_cls_ff, pend_cls_in;
   logic         rsp_valid_ff, rsp_valid_in;
   status_type   status_ff, status_in;
   logic [HANDLE_W-1:0] granted_ff, granted_in;
   class_type    class_ff, class_in;

   link_req_type ram_req;
   link_type     rd_link;

   logic         accept;
   logic         cfg_we;
   class_type    cfg_idx;
   logic         fit_found;
   class_type    fit_cls;
   link_type     sel_head;
   logic         own_hit;
   class_type    own_cls;
   link_type     handle_ext;

   assign busy    = 1'b0;
   assign pready  = 1'b1;
   assign accept  = start & ~busy;
   assign cfg_we  = psel & penable & pwrite & pready;
   assign cfg_idx = paddr[REG_ADDR_W-1:2];
   assign prdata  = DATA_W'(limit_ff[cfg_idx]);

   assign handle_ext = LINK_W'(req_chunk_handle);

   always_comb begin
      limit_in = limit_ff;
      if (cfg_we) limit_in[cfg_idx] = pwdata[SIZE_W-1:0];
   end

   // head of each class with the pop issued last cycle applied
   always_comb begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
         head_eff[c] = (pend_ff && pend_cls_ff == CLASS_W'(c)) ? rd_link : head_ff[c];
      end
   end

   always_comb begin
      fit_found = 1'b0;
      fit_cls   = '0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (req_request_size <= limit_ff[c]) begin
            fit_found = 1'b1;
            fit_cls   = CLASS_W'(c);
         end
      end
   end

   always_comb begin
      own_hit = 1'b0;
      own_cls = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (handle_ext >= LINK_W'(class_base(c)) &&
             handle_ext <  LINK_W'(class_base(c) + class_count(c))) begin
            own_hit = 1'b1;
            own_cls = CLASS_W'(c);
         end
      end
   end

   assign sel_head = head_eff[fit_cls];

   always_comb begin
      head_in      = head_eff;
      pend_in      = 1'b0;
      pend_cls_in  = pend_cls_ff;
      rsp_valid_in = accept;
      status_in    = ST_FREED;
      granted_in   = '0;
      class_in     = '0;
      ram_req      = '0;
      if (accept) begin
         if (command_type'(req_command) == CMD_ALLOC) begin
            priority if (!fit_found) begin
               status_in = ST_TOO_LARGE;
            end else if (sel_head >= LINK_W'(TOTAL_CHUNKS)) begin
               status_in = ST_EXHAUSTED;
               class_in  = fit_cls;
            end else begin
               status_in       = ST_ALLOCATED;
               granted_in      = sel_head[HANDLE_W-1:0];
               class_in        = fit_cls;
               pend_in         = 1'b1;
               pend_cls_in     = fit_cls;
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = sel_head[ADDR_W-1:0];
            end
         end else if (req_handle_present && own_hit) begin
            class_in         = own_cls;
            ram_req.wr_en    = 1'b1;
            ram_req.wr_addr  = ADDR_W'(req_chunk_handle);
            ram_req.wr_data  = head_eff[own_cls];
            head_in[own_cls] = handle_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            limit_ff[c] <= default_limit(c);
            head_ff[c]  <= class_last(c);
         end
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         head_ff      <= head_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_cls_ff <= pend_cls_in;
      status_ff   <= status_in;
      granted_ff  <= granted_in;
      class_ff    <= class_in;
   end

   scpa_link_ram u_link_ram (
      .clock   (clock),
      .reset   (reset),
      .req     (ram_req),
      .rd_link (rd_link)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_granted_handle = granted_ff;
   assign rsp_size_class     = class_ff;

endmodule

// ===== hdl/scpa_checker.sv =====
`include "size_class_pool_allocator_macros.svh"

module scpa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          req_command,
   input logic                          rsp_valid,
   input logic [1:0]                    rsp_status,
   input logic [scpa_pkg::HANDLE_W-1:0] rsp_granted_handle
);
   import scpa_pkg::*;

   `SCPA_ASSERT_NEXT(a_result_follows, clock, reset, start && !busy, rsp_valid)
   `SCPA_ASSERT_NEXT(a_no_spurious, clock, reset, !(start && !busy), !rsp_valid)
   `SCPA_ASSERT_NEXT(a_free_status, clock, reset, start && !busy && req_command == CMD_FREE, rsp_status == ST_FREED)
   `SCPA_ASSERT_SAME(a_grant_zero, clock, reset, rsp_valid && rsp_status != ST_ALLOCATED, rsp_granted_handle == '0)
   `SCPA_ASSERT_SAME(a_grant_range, clock, reset, rsp_valid && rsp_status == ST_ALLOCATED, rsp_granted_handle < TOTAL_CHUNKS)

endmodule

bind size_class_pool_allocator scpa_checker u_scpa_checker (.*);
